// File: sv/ltp_pkg.sv
// ----------------------------------------------------------------------------
// ltp_pkg: shared types and constants of the line time profiler
// Event and status codes, controller states, table and stack geometry, and
// the command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package ltp_pkg;

    localparam int LINE_ENTRIES = 4096;
    localparam int LINE_IDX_W   = $clog2(LINE_ENTRIES);
    localparam int STACK_DEPTH  = 64;
    localparam int STACK_IDX_W  = $clog2(STACK_DEPTH);
    localparam int LEVEL_W      = STACK_IDX_W + 1;
    localparam int TIME_W       = 32;
    localparam int CNT_W        = 32;
    localparam int CMD_W        = 3;
    localparam int STATUS_W     = 3;
    localparam int S_DATA_W     = 48;
    localparam int M_DATA_W     = 80;

    typedef enum logic [CMD_W-1:0] {
        CMD_BEGIN = 3'd0,
        CMD_LINE  = 3'd1,
        CMD_PUSH  = 3'd2,
        CMD_POP   = 3'd3,
        CMD_END   = 3'd4,
        CMD_READ  = 3'd5
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK          = 3'd0,
        ST_NOT_ENABLED = 3'd1,
        ST_ENABLED     = 3'd2,
        ST_EMPTY       = 3'd3,
        ST_FULL        = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        S_CLEAR  = 2'd0,
        S_IDLE   = 2'd1,
        S_DECODE = 2'd2,
        S_EXEC   = 2'd3
    } state_t;

    typedef struct packed {
        logic clear_en;
        logic accept;
        logic fetch;
        logic exec;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic out_free;
    } dp_status_t;

endpackage

// File: sv/ltp_ctrl.sv
// ----------------------------------------------------------------------------
// ltp_ctrl: event sequencer of the line time profiler
// Runs the table clearing pass after reset, then steps each word through
// accept, decode (table read) and execute (write back and result).
// ----------------------------------------------------------------------------
module ltp_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  ltp_pkg::dp_status_t   dp_status,
    output ltp_pkg::ctrl_cmd_t    ctrl_cmd
);

    ltp_pkg::state_t state_reg;
    ltp_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ltp_pkg::S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ltp_pkg::S_CLEAR: begin
                if (dp_status.clear_last) begin
                    state_next = ltp_pkg::S_IDLE;
                end
            end
            ltp_pkg::S_IDLE: begin
                if (s_tvalid) begin
                    state_next = ltp_pkg::S_DECODE;
                end
            end
            ltp_pkg::S_DECODE: begin
                state_next = ltp_pkg::S_EXEC;
            end
            ltp_pkg::S_EXEC: begin
                if (dp_status.out_free) begin
                    state_next = ltp_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = ltp_pkg::S_CLEAR;
            end
        endcase
    end

    always_comb begin
        s_tready          = 1'b0;
        ctrl_cmd.clear_en = 1'b0;
        ctrl_cmd.accept   = 1'b0;
        ctrl_cmd.fetch    = 1'b0;
        ctrl_cmd.exec     = 1'b0;
        case (state_reg)
            ltp_pkg::S_CLEAR: begin
                ctrl_cmd.clear_en = 1'b1;
            end
            ltp_pkg::S_IDLE: begin
                s_tready        = 1'b1;
                ctrl_cmd.accept = s_tvalid;
            end
            ltp_pkg::S_DECODE: begin
                ctrl_cmd.fetch = 1'b1;
            end
            ltp_pkg::S_EXEC: begin
                ctrl_cmd.exec = dp_status.out_free;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

// File: sv/ltp_datapath.sv
// ----------------------------------------------------------------------------
// ltp_datapath: frame stack, line table and result register
// Holds the event word, the frame stack memory, the per-line hit and tick
// memory with its clearing counter, the charge arithmetic and the output word.
// ----------------------------------------------------------------------------
module ltp_datapath (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic [ltp_pkg::S_DATA_W-1:0]     s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [ltp_pkg::M_DATA_W-1:0]     m_tdata,
    input  ltp_pkg::ctrl_cmd_t               ctrl_cmd,
    output ltp_pkg::dp_status_t              dp_status
);

    localparam int FRAME_W = ltp_pkg::TIME_W + ltp_pkg::LINE_IDX_W + 1;
    localparam int ENTRY_W = 2 * ltp_pkg::CNT_W;
    localparam int PAD_W   = ltp_pkg::M_DATA_W - ltp_pkg::STATUS_W - 2 * ltp_pkg::CNT_W
                             - ltp_pkg::LEVEL_W;

    // event word
    ltp_pkg::cmd_t                     cmd_reg;
    logic [ltp_pkg::TIME_W-1:0]        now_reg;
    logic [ltp_pkg::LINE_IDX_W-1:0]    line_reg;
    logic                              skip_reg;

    // control state
    logic [ltp_pkg::LEVEL_W-1:0]       count_reg;
    logic [ltp_pkg::LEVEL_W-1:0]       count_next;
    logic                              enabled_reg;
    logic                              enabled_next;
    logic [ltp_pkg::LINE_IDX_W-1:0]    clr_addr_reg;
    logic                              m_valid_reg;
    logic [ltp_pkg::M_DATA_W-1:0]      m_data_reg;

    // memories
    logic [FRAME_W-1:0]                stack_mem [ltp_pkg::STACK_DEPTH];
    logic [FRAME_W-1:0]                frame_reg;
    logic [ENTRY_W-1:0]                table_mem [ltp_pkg::LINE_ENTRIES];
    logic [ENTRY_W-1:0]                entry_reg;

    logic [ltp_pkg::STACK_IDX_W-1:0]   top_idx;
    logic [ltp_pkg::TIME_W-1:0]        top_stamp;
    logic [ltp_pkg::LINE_IDX_W-1:0]    top_line;
    logic                              top_skip;
    ltp_pkg::status_t                  status;
    logic                              ok;
    logic                              stack_empty;
    logic                              charge;
    logic                              stack_we;
    logic [ltp_pkg::STACK_IDX_W-1:0]   stack_wa;
    logic [FRAME_W-1:0]                stack_wd;
    logic                              table_we;
    logic [ltp_pkg::LINE_IDX_W-1:0]    table_wa;
    logic [ENTRY_W-1:0]                table_wd;
    logic [ltp_pkg::LINE_IDX_W-1:0]    table_ra;
    logic [ltp_pkg::CNT_W-1:0]         old_hits;
    logic [ltp_pkg::CNT_W-1:0]         old_ticks;
    logic [ltp_pkg::CNT_W-1:0]         new_hits;
    logic [ltp_pkg::CNT_W:0]           tick_sum;
    logic [ltp_pkg::CNT_W-1:0]         new_ticks;
    logic [ltp_pkg::TIME_W-1:0]        delta;
    logic [ltp_pkg::CNT_W-1:0]         rd_hits;
    logic [ltp_pkg::CNT_W-1:0]         rd_ticks;

    assign top_idx     = count_reg[ltp_pkg::STACK_IDX_W-1:0] - 1'b1;
    assign top_stamp   = frame_reg[FRAME_W-1 -: ltp_pkg::TIME_W];
    assign top_line    = frame_reg[ltp_pkg::LINE_IDX_W:1];
    assign top_skip    = frame_reg[0];
    assign stack_empty = (count_reg == '0);
    assign old_hits    = entry_reg[ENTRY_W-1 -: ltp_pkg::CNT_W];
    assign old_ticks   = entry_reg[ltp_pkg::CNT_W-1:0];

    // capture the event word
    always_ff @(posedge aclk) begin
        if (ctrl_cmd.accept) begin
            cmd_reg  <= ltp_pkg::cmd_t'(s_tdata[2:0]);
            now_reg  <= s_tdata[34:3];
            line_reg <= s_tdata[46:35];
            skip_reg <= s_tdata[47];
        end
    end

    // status decode
    always_comb begin
        status = ltp_pkg::ST_OK;
        case (cmd_reg)
            ltp_pkg::CMD_BEGIN: begin
                if (enabled_reg) begin
                    status = ltp_pkg::ST_ENABLED;
                end
            end
            ltp_pkg::CMD_LINE, ltp_pkg::CMD_POP: begin
                if (!enabled_reg) begin
                    status = ltp_pkg::ST_NOT_ENABLED;
                end else if (stack_empty) begin
                    status = ltp_pkg::ST_EMPTY;
                end
            end
            ltp_pkg::CMD_PUSH: begin
                if (!enabled_reg) begin
                    status = ltp_pkg::ST_NOT_ENABLED;
                end else if (count_reg == ltp_pkg::LEVEL_W'(ltp_pkg::STACK_DEPTH)) begin
                    status = ltp_pkg::ST_FULL;
                end
            end
            ltp_pkg::CMD_END: begin
                if (!enabled_reg) begin
                    status = ltp_pkg::ST_NOT_ENABLED;
                end
            end
            default: begin
                status = ltp_pkg::ST_OK;
            end
        endcase
    end

    assign ok     = (status == ltp_pkg::ST_OK);
    assign charge = ok && !top_skip && !stack_empty &&
                    (cmd_reg == ltp_pkg::CMD_LINE || cmd_reg == ltp_pkg::CMD_POP ||
                     cmd_reg == ltp_pkg::CMD_END);

    // next stack level and enable
    always_comb begin
        count_next   = count_reg;
        enabled_next = enabled_reg;
        if (ok) begin
            case (cmd_reg)
                ltp_pkg::CMD_BEGIN: enabled_next = 1'b1;
                ltp_pkg::CMD_PUSH:  count_next   = count_reg + 1'b1;
                ltp_pkg::CMD_POP:   count_next   = count_reg - 1'b1;
                ltp_pkg::CMD_END: begin
                    count_next   = '0;
                    enabled_next = 1'b0;
                end
                default: count_next = count_reg;
            endcase
        end
    end

    // charge arithmetic: wrap the difference, saturate the counters
    assign delta     = now_reg - top_stamp;
    assign new_hits  = (old_hits == '1) ? old_hits : old_hits + 1'b1;
    assign tick_sum  = {1'b0, old_ticks} + {1'b0, delta};
    assign new_ticks = tick_sum[ltp_pkg::CNT_W] ? '1 : tick_sum[ltp_pkg::CNT_W-1:0];

    // frame stack write: push a new frame, or move the top frame to the new line
    always_comb begin
        stack_we = 1'b0;
        stack_wa = top_idx;
        stack_wd = {(top_skip ? top_stamp : now_reg), line_reg, top_skip};
        if (ctrl_cmd.exec && ok) begin
            if (cmd_reg == ltp_pkg::CMD_PUSH) begin
                stack_we = 1'b1;
                stack_wa = count_reg[ltp_pkg::STACK_IDX_W-1:0];
                stack_wd = {now_reg, line_reg, skip_reg};
            end else if (cmd_reg == ltp_pkg::CMD_LINE) begin
                stack_we = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (stack_we) begin
            stack_mem[stack_wa] <= stack_wd;
        end
        if (ctrl_cmd.accept) begin
            frame_reg <= stack_mem[top_idx];
        end
    end

    // line table: clearing pass, charge write back, entry read
    always_comb begin
        table_we = 1'b0;
        table_wa = top_line;
        table_wd = {new_hits, new_ticks};
        if (ctrl_cmd.clear_en) begin
            table_we = 1'b1;
            table_wa = clr_addr_reg;
            table_wd = '0;
        end else if (ctrl_cmd.exec && charge) begin
            table_we = 1'b1;
        end
    end

    assign table_ra = (cmd_reg == ltp_pkg::CMD_READ) ? line_reg : top_line;

    always_ff @(posedge aclk) begin
        if (table_we) begin
            table_mem[table_wa] <= table_wd;
        end
        if (ctrl_cmd.fetch) begin
            entry_reg <= table_mem[table_ra];
        end
    end

    assign rd_hits  = (cmd_reg == ltp_pkg::CMD_READ) ? old_hits : '0;
    assign rd_ticks = (cmd_reg == ltp_pkg::CMD_READ) ? old_ticks : '0;

    // control registers and output word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            enabled_reg  <= 1'b0;
            clr_addr_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (ctrl_cmd.clear_en) begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (ctrl_cmd.exec) begin
                count_reg   <= count_next;
                enabled_reg <= enabled_next;
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl_cmd.exec) begin
            m_data_reg <= {{PAD_W{1'b0}}, count_next, rd_ticks, rd_hits, status};
        end
    end

    assign m_tvalid             = m_valid_reg;
    assign m_tdata              = m_data_reg;
    assign dp_status.out_free   = !m_valid_reg || m_tready;
    assign dp_status.clear_last = ctrl_cmd.clear_en && (clr_addr_reg == '1);

endmodule

// File: sv/line_time_profiler.sv
// ----------------------------------------------------------------------------
// line_time_profiler: per-line hit and time profiler fed by trace events
// Usage:
//   s_ channel: one event word per handshake (begin, line, push, pop, end,
//   read) with timestamp, line index and skip flag. m_ channel: one result
//   word per event with status, read-back hits and ticks, and stack level.
//   Each word passes through accept with frame stack read, line table
//   read, then write back and result load. The line table address comes out
//   of the registered frame stack read, so the two reads cannot overlap; the
//   next word is taken the cycle after that.
//   After reset the line table is cleared one entry a cycle, all 4096 entries,
//   with s_tready low throughout; the stack is empty and profiling off.
//   A stalled m_ side holds its word in the output register; one further
//   event is accepted and processed, then held in its last step until the
//   waiting word is taken.
// ----------------------------------------------------------------------------
module line_time_profiler (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // cmd[2:0], time_now[34:3], line_index[46:35], skip_frame[47]
    input  logic [ltp_pkg::S_DATA_W-1:0]  s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // status[2:0], read_hits[34:3], read_time[66:35], stack_level[73:67], zero
    output logic [ltp_pkg::M_DATA_W-1:0]  m_tdata
);

    ltp_pkg::ctrl_cmd_t  ctrl_cmd;
    ltp_pkg::dp_status_t dp_status;

    ltp_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .dp_status (dp_status),
        .ctrl_cmd  (ctrl_cmd)
    );

    ltp_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .ctrl_cmd  (ctrl_cmd),
        .dp_status (dp_status)
    );

endmodule
